[design/crc_framed_container_checker_assert.svh]
// ----------------------------------------------------------------------------
// crc_framed_container_checker_assert.svh
// assertion macros shared by the container checker rtl
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_CONTAINER_CHECKER_ASSERT_SVH
`define CRC_FRAMED_CONTAINER_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFCC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("container checker assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CFCC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("container checker assertion failed");

`endif

[design/cfcc_pkg.sv]
// ----------------------------------------------------------------------------
// cfcc_pkg
// shared constants, types and the crc-32 byte step for the container checker
// ----------------------------------------------------------------------------
`default_nettype none

package cfcc_pkg;

	// file geometry
	localparam int MAX_FILE_BYTES = 4096;
	localparam int HEADER_BYTES   = 18;
	// byte counter saturates at MAX_FILE_BYTES + 1
	localparam int CNT_W          = $clog2(MAX_FILE_BYTES + 2);

	// header layout, byte positions
	localparam int VER_POS = 8;
	localparam int LEN_POS = 10;
	localparam int CRC_POS = 14;

	// reflected crc-32
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAGIC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH  = 2'd2;

	// configuration register contents
	typedef struct packed {
		logic [63:0] magic;
		logic [15:0] version;
		logic [11:0] length;
	} cfg_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       done;
		logic       verdict;
	} res_t;

	// one byte of the reflected crc, lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/crc_framed_container_checker.sv]
// ----------------------------------------------------------------------------
// crc_framed_container_checker
// checks an 18-byte container header and the crc-32 of the payload that follows
// ----------------------------------------------------------------------------
// The block takes one file byte per transaction and returns one result per
// byte, one byte per clock cycle unless out_ready holds results back. Each
// byte passes an input register and a result register, moving on once the
// result register has room; between them lie one unrolled 8-bit step of the
// reflected crc-32, header capture and the final compare. The result on the
// byte marked final carries done_res and the verdict (0 ok, 1 corrupt), and
// the block is then ready for the next file. The user must write configuration
// through the cfg channel while no file is in flight; this is not enforced.
`default_nettype none

module crc_framed_container_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration write channel
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [cfcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [63:0]                    cfg_data,
	// input byte channel
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [7:0]                     file_byte,
	input  wire                            final_byte,
	// result channel
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [7:0]                     payload_byte,
	output logic                           payload_valid,
	output logic                           done_res,
	output logic                           verdict
);
	import cfcc_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       advance;

	assign cfg_ready = 1'b1;

	cfcc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// move the registered byte into the result register when it has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= file_byte;
			final_s1 <= final_byte;
		end
	end

	cfcc_check_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.file_byte  (byte_s1),
		.final_byte (final_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = res_q.payload_byte;
	assign payload_valid = res_q.payload_valid;
	assign done_res      = res_q.done;
	assign verdict       = res_q.verdict;

	`include "crc_framed_container_checker_assert.svh"

	// a verdict only ever rides on the last byte of a file
	`CFCC_ASSERT_IMPL(a_verdict_only_when_done, out_valid && !done_res, !verdict)
	// input stalls only when both stages are full and the output is blocked
	`CFCC_ASSERT_IMPL(a_stall_reason, !in_ready, valid_s1 && out_valid_q && !out_ready)
	// a byte held in the input register keeps its value until it moves on
	`CFCC_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1) && $stable(final_s1))

endmodule

`default_nettype wire

[design/cfcc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cfcc_cfg_regs
// configuration register file: expected magic, version and payload length
// ----------------------------------------------------------------------------
`default_nettype none

module cfcc_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	input  wire  [cfcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [63:0]                    cfg_data,
	output cfcc_pkg::cfg_t                 cfg
);
	import cfcc_pkg::*;

	cfg_t cfg_q;

	// register write decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_MAGIC:   cfg_q.magic   <= cfg_data;
				CFG_IDX_VERSION: cfg_q.version <= cfg_data[15:0];
				CFG_IDX_LENGTH:  cfg_q.length  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/cfcc_check_core.sv]
// ----------------------------------------------------------------------------
// cfcc_check_core
// per-file state: header capture, payload crc, byte count and final verdict
// ----------------------------------------------------------------------------
`default_nettype none

module cfcc_check_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,
	input  wire  [7:0]           file_byte,
	input  wire                  final_byte,
	input  cfcc_pkg::cfg_t       cfg,
	output cfcc_pkg::res_t       res
);
	import cfcc_pkg::*;

	localparam logic [CNT_W-1:0] POS_VER = CNT_W'(VER_POS);
	localparam logic [CNT_W-1:0] POS_LEN = CNT_W'(LEN_POS);
	localparam logic [CNT_W-1:0] POS_CRC = CNT_W'(CRC_POS);
	localparam logic [CNT_W-1:0] POS_PAY = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] POS_MAX = CNT_W'(MAX_FILE_BYTES);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FILE_BYTES + 1);

	logic [CNT_W-1:0] count_q,   count_d;
	logic [31:0]      crc_q,     crc_d;
	logic             magic_ok_q, magic_ok_d;
	logic [15:0]      hdr_ver_q, hdr_ver_d;
	logic [31:0]      hdr_len_q, hdr_len_d;
	logic [31:0]      hdr_crc_q, hdr_crc_d;

	logic [CNT_W-1:0] ver_off, len_off, crc_off;
	logic             pay_valid;
	logic             bad;

	assign ver_off = count_q - POS_VER;
	assign len_off = count_q - POS_LEN;
	assign crc_off = count_q - POS_CRC;

	// header capture and payload crc for the byte at count_q
	always_comb begin
		magic_ok_d = magic_ok_q;
		hdr_ver_d  = hdr_ver_q;
		hdr_len_d  = hdr_len_q;
		hdr_crc_d  = hdr_crc_q;
		crc_d      = crc_q;
		pay_valid  = 1'b0;
		if (count_q < POS_VER) begin
			if (cfg.magic[8*count_q[2:0] +: 8] != file_byte) begin
				magic_ok_d = 1'b0;
			end
		end else if (count_q < POS_LEN) begin
			hdr_ver_d[8*ver_off[0] +: 8] = file_byte;
		end else if (count_q < POS_CRC) begin
			hdr_len_d[8*len_off[1:0] +: 8] = file_byte;
		end else if (count_q < POS_PAY) begin
			hdr_crc_d[8*crc_off[1:0] +: 8] = file_byte;
		end else if (count_q < POS_MAX) begin
			pay_valid = 1'b1;
			crc_d     = crc_byte(crc_q, file_byte);
		end
		count_d = (count_q < CNT_SAT) ? count_q + 1'b1 : count_q;
	end

	// verdict on the final byte, size is the count after this byte
	always_comb begin
		bad = (count_d > POS_MAX)
			|| (count_d < POS_PAY)
			|| !magic_ok_d
			|| (hdr_ver_d != cfg.version)
			|| (hdr_len_d != {20'd0, cfg.length})
			|| (count_d != POS_PAY + {1'b0, cfg.length})
			|| (~crc_d != hdr_crc_d);
	end

	// result for the byte in the input register
	always_comb begin
		res.payload_byte  = file_byte;
		res.payload_valid = pay_valid;
		res.done          = final_byte;
		res.verdict       = final_byte & bad;
	end

	// per-file state, back to reset values after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			magic_ok_q <= 1'b1;
			hdr_ver_q  <= '0;
			hdr_len_q  <= '0;
			hdr_crc_q  <= '0;
		end else if (advance) begin
			if (final_byte) begin
				count_q    <= '0;
				crc_q      <= CRC_INIT;
				magic_ok_q <= 1'b1;
				hdr_ver_q  <= '0;
				hdr_len_q  <= '0;
				hdr_crc_q  <= '0;
			end else begin
				count_q    <= count_d;
				crc_q      <= crc_d;
				magic_ok_q <= magic_ok_d;
				hdr_ver_q  <= hdr_ver_d;
				hdr_len_q  <= hdr_len_d;
				hdr_crc_q  <= hdr_crc_d;
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/crc_framed_container_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_framed_container_checker_tb
// self-checking bench for the container header and crc-32 checker
// ----------------------------------------------------------------------------
// Streams whole container files through the byte channel and predicts every
// result transaction: echoed byte, payload flag and, on the last byte, the
// ok/corrupt verdict. Files are mostly well formed with random content under
// several register settings; the rest carry one header, size or crc fault,
// are cut short, or are noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module crc_framed_container_checker_tb;

	import cfcc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 350;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 4;
	localparam int SHOWN_ERRORS = 10;

	typedef enum int {
		FILE_OK,
		BAD_MAGIC,
		BAD_VERSION,
		BAD_LENGTH,
		SIZE_MISMATCH,
		BAD_CRC,
		TRUNCATED,
		NOISE
	} file_kind_t;

	typedef struct {
		logic [7:0] data;
		logic       is_last;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_MAGIC;
	logic [63:0]          cfg_data = '0;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] file_byte = '0;
	logic       final_byte = 1'b0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       done_res;
	logic       verdict;

	crc_framed_container_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.file_byte     (file_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.done_res      (done_res),
		.verdict       (verdict)
	);

	// register copies as written through the cfg channel
	logic [63:0] cfg_magic = '0;
	logic [15:0] cfg_version = '0;
	logic [11:0] cfg_length = '0;

	// per-file state of the checker model
	logic [12:0] file_count = '0;
	logic [31:0] payload_crc = CRC_INIT;
	logic        magic_ok = 1'b1;
	logic [15:0] hdr_version = '0;
	logic [31:0] hdr_length = '0;
	logic [31:0] hdr_crc = '0;

	byte_item_t  byte_pending[$];
	res_t        expected_results[$];
	logic [7:0]  file_buf[$];

	bit in_sent = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int idle_pct = 20;
	int cycle_count = 0;
	int bytes_queued = 0;
	int files_queued = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int files_ok = 0;
	int files_bad = 0;
	int mismatches = 0;

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// one byte of the reflected crc-32, lsb first
	function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// advance the file model by one byte and queue its result
	task automatic predict_byte(input logic [7:0] b, input logic fin);
		res_t        r;
		logic [12:0] pos;
		logic        bad;
		pos = file_count;
		r = '0;
		r.payload_byte = b;
		if (pos < VER_POS) begin
			if (cfg_magic[8*pos +: 8] != b)
				magic_ok = 1'b0;
		end else if (pos < LEN_POS) begin
			hdr_version[8*(pos-VER_POS) +: 8] = b;
		end else if (pos < CRC_POS) begin
			hdr_length[8*(pos-LEN_POS) +: 8] = b;
		end else if (pos < HEADER_BYTES) begin
			hdr_crc[8*(pos-CRC_POS) +: 8] = b;
		end else if (pos < MAX_FILE_BYTES) begin
			r.payload_valid = 1'b1;
			payload_crc = crc32_shift_byte(payload_crc, b);
		end
		if (file_count < MAX_FILE_BYTES + 1)
			file_count = file_count + 13'd1;
		if (fin) begin
			bad = (file_count > MAX_FILE_BYTES) || (file_count < HEADER_BYTES) || !magic_ok ||
				(hdr_version != cfg_version) || (hdr_length != {20'd0, cfg_length}) ||
				(64'(file_count) != 64'(HEADER_BYTES) + 64'(hdr_length)) ||
				(~payload_crc != hdr_crc);
			r.done = 1'b1;
			r.verdict = bad;
			file_count = '0;
			payload_crc = CRC_INIT;
			magic_ok = 1'b1;
			hdr_version = '0;
			hdr_length = '0;
			hdr_crc = '0;
		end
		expected_results.push_back(r);
	endtask

	// byte driver
	always @(negedge clk) begin : drive_bytes
		byte_item_t it;
		if (arst_n && (!in_valid || in_sent)) begin
			in_sent = 1'b0;
			if (byte_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				it = byte_pending.pop_front();
				in_valid <= 1'b1;
				file_byte <= it.data;
				final_byte <= it.is_last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// predict on each byte transaction, check each result transaction
	always @(posedge clk) begin : track_results
		res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_byte(file_byte, final_byte);
				in_sent = 1'b1;
				bytes_taken++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("unexpected result: byte %h valid %b done %b verdict %b",
							payload_byte, payload_valid, done_res, verdict);
				end else begin
					want = expected_results.pop_front();
					if (want.done) begin
						if (want.verdict)
							files_bad++;
						else
							files_ok++;
					end
					if (payload_byte !== want.payload_byte || payload_valid !== want.payload_valid ||
						done_res !== want.done || verdict !== want.verdict) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS)
							$display("result %0d: expected byte %h valid %b done %b verdict %b, %s %h %b %b %b",
								results_seen, want.payload_byte, want.payload_valid, want.done,
								want.verdict, "got", payload_byte, payload_valid, done_res, verdict);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// register write through the cfg channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_IDX_MAGIC:   cfg_magic = data;
			CFG_IDX_VERSION: cfg_version = data[15:0];
			CFG_IDX_LENGTH:  cfg_length = data[11:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued byte is taken and every result has come back
	task automatic wait_drained();
		@(posedge clk);
		while (byte_pending.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// build a container image: magic, version and length as given, random payload and its crc
	task automatic make_file(input logic [63:0] magic, input logic [15:0] ver,
		input logic [31:0] hlen, input int npay, input logic [31:0] crc_flip);
		logic [31:0] c;
		logic [7:0]  b;
		file_buf.delete();
		c = CRC_INIT;
		for (int i = 0; i < 8; i++)
			file_buf.push_back(magic[8*i +: 8]);
		file_buf.push_back(ver[7:0]);
		file_buf.push_back(ver[15:8]);
		for (int i = 0; i < 4; i++)
			file_buf.push_back(hlen[8*i +: 8]);
		repeat (4) file_buf.push_back(8'd0);
		for (int i = 0; i < npay; i++) begin
			b = 8'($urandom);
			file_buf.push_back(b);
			if (HEADER_BYTES + i < MAX_FILE_BYTES)
				c = crc32_shift_byte(c, b);
		end
		c = ~c ^ crc_flip;
		for (int i = 0; i < 4; i++)
			file_buf[CRC_POS+i] = c[8*i +: 8];
	endtask

	// queue part of the image; fin marks the last queued byte as final
	task automatic send_range(input int first, input int stop, input bit fin);
		byte_item_t it;
		for (int i = first; i < stop; i++) begin
			it.data = file_buf[i];
			it.is_last = fin && (i == stop - 1);
			byte_pending.push_back(it);
			bytes_queued++;
		end
		if (fin)
			files_queued++;
	endtask

	// one file of the given kind against the current registers
	task automatic queue_file(input file_kind_t kind);
		logic [63:0] m;
		logic [15:0] v;
		logic [31:0] hl;
		logic [31:0] flip;
		int          np;
		int          cut;
		m = cfg_magic;
		v = cfg_version;
		hl = {20'd0, cfg_length};
		np = int'(cfg_length);
		flip = '0;
		cut = 0;
		case (kind)
			BAD_MAGIC:   m ^= 64'd1 << $urandom_range(0, 63);
			BAD_VERSION: v ^= 16'd1 << $urandom_range(0, 15);
			BAD_LENGTH: begin
				hl ^= 32'd1 << $urandom_range(0, 31);
				np = (hl < 64) ? int'(hl) : int'(cfg_length);
			end
			SIZE_MISMATCH: begin
				if (cfg_length == 0 || $urandom_range(0, 1))
					np = int'(cfg_length) + $urandom_range(1, 3);
				else
					np = int'(cfg_length) - 1;
			end
			BAD_CRC:   flip = 32'd1 << $urandom_range(0, 31);
			TRUNCATED: cut = $urandom_range(1, HEADER_BYTES - 1);
			default: ;
		endcase
		if (kind == NOISE) begin
			file_buf.delete();
			repeat ($urandom_range(1, 40)) file_buf.push_back(8'($urandom));
		end else begin
			make_file(m, v, hl, np, flip);
		end
		send_range(0, (cut != 0) ? cut : file_buf.size(), 1'b1);
	endtask

	// stimulus sequence
	initial begin : stimulus
		int         rand_start;
		int         phase_no;
		file_kind_t kind;
		int         leftover;

		// reset
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: empty-payload file, then files cut at one and seventeen bytes
		make_file(64'd0, 16'd0, 32'd0, 0, 32'd0);
		send_range(0, HEADER_BYTES, 1'b1);
		send_range(0, 1, 1'b1);
		send_range(0, HEADER_BYTES - 1, 1'b1);
		wait_drained();

		// all-ones magic and version, one file of each fault
		write_reg(CFG_IDX_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_IDX_VERSION, 64'h0000_0000_0000_FFFF);
		write_reg(CFG_IDX_LENGTH, 64'd5);
		queue_file(FILE_OK);
		for (int k = BAD_MAGIC; k <= NOISE; k++)
			queue_file(file_kind_t'(k));
		wait_drained();

		// sender pauses mid-file until every result is back
		make_file(cfg_magic, cfg_version, {20'd0, cfg_length}, int'(cfg_length), 32'd0);
		send_range(0, LEN_POS, 1'b0);
		wait_drained();
		send_range(LEN_POS, file_buf.size(), 1'b1);
		wait_drained();

		// random files under a series of register settings
		rand_start = bytes_queued;
		phase_no = 0;
		while (bytes_queued - rand_start < RANDOM_BYTES) begin
			phase_no++;
			write_reg(CFG_IDX_MAGIC, {$urandom, $urandom});
			write_reg(CFG_IDX_VERSION, 64'($urandom_range(0, 65535)));
			write_reg(CFG_IDX_LENGTH, (phase_no == 1) ? 64'd0 : 64'($urandom_range(1, 24)));
			idle_pct = (phase_no == 3) ? 0 : 20;
			if (phase_no == 2)
				hold_req = 1'b1;
			repeat (6) begin
				if ($urandom_range(0, 99) < 75)
					kind = FILE_OK;
				else
					kind = file_kind_t'($urandom_range(BAD_MAGIC, NOISE));
				queue_file(kind);
			end
			wait_drained();
		end
		idle_pct = 20;

		// a length that can only overrun the size limit, so no file can match it
		write_reg(CFG_IDX_LENGTH, 64'd4095);
		make_file(cfg_magic, cfg_version, {20'd0, cfg_length}, 8, 32'd0);
		send_range(0, file_buf.size(), 1'b1);
		wait_drained();

		leftover = expected_results.size();
		if (leftover != 0)
			$display("%0d expected results never arrived", leftover);
		$display("covered %0d files in %0d bytes: %0d judged ok, %0d corrupt",
			files_queued, bytes_taken, files_ok, files_bad);
		$display("header, size, crc, short-file and over-limit length faults under back-pressure; %0d mismatches",
			mismatches);
		if (mismatches == 0 && leftover == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[crc_framed_container_checker.f]
+incdir+design
design/cfcc_pkg.sv
design/cfcc_cfg_regs.sv
design/cfcc_check_core.sv
design/crc_framed_container_checker.sv
tb/sv/crc_framed_container_checker_tb.sv
